@@ hdl/secant_root_step_macros.svh @@
// ----------------------------------------------------------------------------
// secant_root_step_macros.svh
// Assertion macros for the secant root-search engine. Each macro samples on
// the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SECANT_ROOT_STEP_MACROS_SVH
`define SECANT_ROOT_STEP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("secant_root_step: assertion failed");
// next-cycle implication
`define SRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("secant_root_step: assertion failed");
`else
`define SRS_ASSERT_IMP(label, ante, cons)
`define SRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg
// Types, codes and helpers shared by the secant root-search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  // fixed-point format of x and err values
  localparam int FRAC_BITS = 16;

  // serial arithmetic step counts
  localparam int CNT_W     = 6;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 33;

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_ITER_LIMIT = 1'b0;
  localparam logic REG_TOLERANCE  = 1'b1;
  localparam logic [15:0] ITER_LIMIT_RESET = 16'd100;
  localparam logic [30:0] TOLERANCE_RESET  = 31'd66;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // status codes
  typedef logic [2:0] status_t;
  localparam status_t STAT_CONTINUE    = 3'd0;
  localparam status_t STAT_CONVERGED   = 3'd1;
  localparam status_t STAT_GAVE_UP     = 3'd2;
  localparam status_t STAT_TOO_MANY    = 3'd3;
  localparam status_t STAT_NOT_STARTED = 3'd4;

  // saturation limits of a Q16.16 word
  localparam logic [31:0] X_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] X_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] first_x;
    logic signed [31:0] first_err;
    logic signed [31:0] second_x;
    logic signed [31:0] second_err;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] next_x;
    logic               next_x_valid;
    logic [15:0]        steps_taken;
  } out_item_t;

  // magnitude of a 32-bit two's complement value (2^31 fits unsigned)
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // magnitude of a 33-bit difference of two 32-bit values
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] t;
    t = v[32] ? (~v + 33'd1) : v;
    mag33 = t[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/secant_root_step.sv @@
// ----------------------------------------------------------------------------
// secant_root_step
// Secant root-search engine in signed Q16.16 with an APB register port.
// Path, accept to out_valid: point = tolerance product, decide, secant product,
//   divide setup, divide (one quotient bit a cycle); start skips the tolerance
//   product; equal stored errors skip product and divide, saturation the divide.
// Throughput: one item in flight; in_ready rises together with out_valid.
// Reset (sync, active low) clears the pair and count, loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "secant_root_step_macros.svh"

module secant_root_step import srs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input items
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  // result items
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_TOL_MUL, S_DECIDE, S_PREP, S_MUL, S_DIV_SETUP, S_DIV, S_FINISH
  } state_t;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t state_r;

  // configuration registers
  logic [15:0] iter_limit_r;
  logic [30:0] tol_r;

  // search state
  logic [31:0] pa_x_r, pa_err_r, pb_x_r, pb_err_r;
  logic [31:0] sem_r;
  logic [15:0] step_r;
  logic        started_r;

  // item and datapath registers
  in_item_t         item_r;
  status_t          status_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      mul_p_r;
  logic [31:0]      mul_m_r;
  logic [31:0]      div_d_r;
  logic [31:0]      rem_r;
  logic [32:0]      quo_r;
  logic             q_neg_r;
  logic             ovf_r;
  logic             guess_valid_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // ---------------- register port ----------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= ITER_LIMIT_RESET;
      tol_r        <= TOLERANCE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ITER_LIMIT: iter_limit_r <= pwdata[15:0];
        REG_TOLERANCE:  tol_r        <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ITER_LIMIT: prdata = {16'd0, iter_limit_r};
      REG_TOLERANCE:  prdata = {1'b0, tol_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------- shift-add multiplier step ----------------
  logic [32:0] mul_sum;
  logic [63:0] mul_p_nxt;
  assign mul_sum   = {1'b0, mul_p_r[63:32]} + (mul_p_r[0] ? {1'b0, mul_m_r} : 33'd0);
  assign mul_p_nxt = {mul_sum, mul_p_r[31:1]};

  // ---------------- decision ----------------
  logic [31:0] me, ma, mb, m1, m2, start_mag;
  logic [15:0] step_inc;
  logic [63:0] rel_lhs;
  logic        too_many, abs_conv, rel_conv;
  logic        same_ab, opp_ae, opp_be;
  status_t     dec_status;
  logic        repl_a, repl_b;

  assign me = mag32(item_r.first_err);
  assign ma = mag32(pa_err_r);
  assign mb = mag32(pb_err_r);
  assign m1 = mag32(item_r.first_err);
  assign m2 = mag32(item_r.second_err);
  assign start_mag = (m1 > m2) ? m1 : m2;

  assign step_inc = (step_r != 16'hFFFF) ? step_r + 16'd1 : step_r;
  assign too_many = step_inc > iter_limit_r;
  assign rel_lhs  = {{(32 - FRAC_BITS){1'b0}}, me, {FRAC_BITS{1'b0}}};
  assign abs_conv = me < {1'b0, tol_r};
  assign rel_conv = rel_lhs < mul_p_r;

  // sign relations, zero counting as neither sign
  assign same_ab = (pa_err_r != '0) && (pb_err_r != '0) && (pa_err_r[31] == pb_err_r[31]);
  assign opp_ae  = (pa_err_r != '0) && (item_r.first_err != '0)
                   && (pa_err_r[31] != item_r.first_err[31]);
  assign opp_be  = (pb_err_r != '0) && (item_r.first_err != '0)
                   && (pb_err_r[31] != item_r.first_err[31]);

  always_comb begin
    dec_status = STAT_CONTINUE;
    repl_a     = 1'b0;
    repl_b     = 1'b0;
    if (too_many) begin
      dec_status = STAT_TOO_MANY;
    end else if (abs_conv || rel_conv) begin
      dec_status = STAT_CONVERGED;
    end else if (ma > me && ma > mb) begin
      repl_a = 1'b1;
    end else if (mb > me && mb > ma) begin
      repl_b = 1'b1;
    end else if (same_ab) begin
      if (opp_ae) begin
        repl_a = 1'b1;
      end else if (opp_be) begin
        repl_b = 1'b1;
      end else begin
        dec_status = STAT_GAVE_UP;
      end
    end else begin
      dec_status = STAT_GAVE_UP;
    end
  end

  // ---------------- secant setup ----------------
  logic [32:0] de, dx;
  logic        de_zero;
  assign de      = {pa_err_r[31], pa_err_r} - {pb_err_r[31], pb_err_r};
  assign dx      = {pa_x_r[31], pa_x_r} - {pb_x_r[31], pb_x_r};
  assign de_zero = (de == '0);

  // quotient of 2^33 or more always saturates the guess
  logic ovf_nxt;
  assign ovf_nxt = {1'b0, mul_p_r[63:33]} >= div_d_r;

  // ---------------- restoring divider step ----------------
  logic [32:0] div_t, div_diff;
  logic        div_ge;
  logic [31:0] rem_nxt;
  logic [32:0] quo_nxt;
  assign div_t    = {rem_r, quo_r[32]};
  assign div_diff = div_t - {1'b0, div_d_r};
  assign div_ge   = div_t >= {1'b0, div_d_r};
  assign rem_nxt  = div_ge ? div_diff[31:0] : div_t[31:0];
  assign quo_nxt  = {quo_r[31:0], div_ge};

  // ---------------- final guess ----------------
  logic [34:0] q_s, r_sum;
  logic [31:0] fin_x;
  assign q_s   = q_neg_r ? (~{2'b00, quo_r} + 35'd1) : {2'b00, quo_r};
  assign r_sum = {{3{pb_x_r[31]}}, pb_x_r} - q_s;

  always_comb begin
    if (!guess_valid_r) begin
      fin_x = '0;
    end else if (ovf_r) begin
      fin_x = q_neg_r ? X_MAX : X_MIN;
    end else if (r_sum[34:31] != {4{r_sum[34]}}) begin
      fin_x = r_sum[34] ? X_MIN : X_MAX;
    end else begin
      fin_x = r_sum[31:0];
    end
  end

  logic can_load;
  assign can_load = !out_valid_r || out_ready;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pa_x_r      <= '0;
      pa_err_r    <= '0;
      pb_x_r      <= '0;
      pb_err_r    <= '0;
      sem_r       <= '0;
      step_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a result taken while the next one loads stays valid through S_FINISH
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            mul_m_r <= sem_r;
            mul_p_r <= {32'd0, 1'b0, tol_r};
            cnt_r   <= '0;
            state_r <= (in_data.operation == OP_START) ? S_DECIDE : S_TOL_MUL;
          end
        end
        S_TOL_MUL: begin
          mul_p_r <= mul_p_nxt;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == MUL_LAST) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (item_r.operation == OP_START) begin
            pa_x_r    <= item_r.first_x;
            pa_err_r  <= item_r.first_err;
            pb_x_r    <= item_r.second_x;
            pb_err_r  <= item_r.second_err;
            sem_r     <= start_mag;
            step_r    <= '0;
            started_r <= 1'b1;
            status_r  <= STAT_CONTINUE;
          end else if (!started_r) begin
            status_r <= STAT_NOT_STARTED;
          end else begin
            step_r   <= step_inc;
            status_r <= dec_status;
            if (repl_a) begin
              pa_x_r   <= item_r.first_x;
              pa_err_r <= item_r.first_err;
            end
            if (repl_b) begin
              pb_x_r   <= item_r.first_x;
              pb_err_r <= item_r.first_err;
            end
          end
          state_r <= S_PREP;
        end
        S_PREP: begin
          mul_m_r       <= mag33(dx);
          mul_p_r       <= {32'd0, mag32(pb_err_r)};
          div_d_r       <= mag33(de);
          q_neg_r       <= pb_err_r[31] ^ dx[32] ^ de[32];
          guess_valid_r <= !de_zero;
          ovf_r         <= 1'b0;
          cnt_r         <= '0;
          state_r       <= de_zero ? S_FINISH : S_MUL;
        end
        S_MUL: begin
          mul_p_r <= mul_p_nxt;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == MUL_LAST) begin
            state_r <= S_DIV_SETUP;
          end
        end
        S_DIV_SETUP: begin
          ovf_r   <= ovf_nxt;
          rem_r   <= {1'b0, mul_p_r[63:33]};
          quo_r   <= mul_p_r[32:0];
          cnt_r   <= '0;
          state_r <= ovf_nxt ? S_FINISH : S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (can_load) begin
            out_data_r.status       <= status_r;
            out_data_r.next_x       <= fin_x;
            out_data_r.next_x_valid <= guess_valid_r;
            out_data_r.steps_taken  <= step_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  `SRS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SRS_ASSERT_IMP(a_divisor_nonzero, state_r == S_DIV, div_d_r != '0)
  `SRS_ASSERT_IMP(a_count_clear_unstarted, !started_r, step_r == '0)
  `SRS_ASSERT_NEXT(a_result_loaded, (state_r == S_FINISH) && can_load, out_valid_r)

endmodule

`default_nettype wire
